[rtl/core/w2su_pkg.sv]
`default_nettype none

package w2su_pkg;

  localparam int unsigned MaxColumns = 1024;
  localparam int unsigned MaxRows    = 4096;
  localparam int unsigned MinSize    = 3;
  localparam int unsigned SampleBits = 16;

  localparam int unsigned ColBits    = 10;
  localparam int unsigned RowBits    = 12;
  localparam int unsigned ColCfgBits = 11;
  localparam int unsigned RowCfgBits = 13;
  localparam int unsigned CfgBits    = 13;

  localparam int unsigned LapBits    = SampleBits + 3;
  localparam int unsigned BaseBits   = SampleBits + 2;
  localparam int unsigned ProdBits   = 36;
  localparam int unsigned FracShift  = 16;
  localparam int unsigned TermBits   = ProdBits - FracShift;
  localparam int unsigned ResBits    = TermBits + 1;

  localparam logic signed [SampleBits-1:0] SampleMax = {1'b0, {(SampleBits-1){1'b1}}};
  localparam logic signed [SampleBits-1:0] SampleMin = {1'b1, {(SampleBits-1){1'b0}}};
  localparam logic [ProdBits-1:0] RoundHalf = ProdBits'(1) << (FracShift - 1);

  localparam logic RegGridColumns = 1'b0;
  localparam logic RegGridRows    = 1'b1;

  typedef struct packed {
    logic [SampleBits-1:0] g_one;
    logic [SampleBits-1:0] g_two;
    logic [SampleBits-1:0] prev;
    logic [SampleBits-1:0] coef;
  } w2su_word_t;

endpackage

`default_nettype wire

[rtl/core/wave2d_stencil_update.sv]
// Five-point stencil update for one time step of the 2-D wave equation.
// Grid points stream in on the slave side in raster order, one request per
// point: tdata carries the current field, the previous field and the squared
// coefficient, and tuser marks the first point of a grid. For every point
// (r, k) with r >= 2 and k >= 2 inside the grid, the master side emits the
// updated value of interior point (r-1, k-1) with its row and column, and
// tlast marks the final interior point. Boundary points produce no request.
// The grid size comes from the grid_columns and grid_rows registers, written
// through the cfg port; the user writes them only while the block is idle, which the block does not enforce.
// One point is accepted per clock cycle unless the master side stalls. The result
// for the point that completes a neighborhood leaves the line memory read at the
// accepting edge and then passes the laplacian, the multiply and the rounding and
// saturation stages, each registered, to the master side. The single 1024 x 64
// line memory is read and written once per point, which sets the rate of one
// point a cycle.
// Each stage only waits when the stage after it is full, so points keep
// entering while a result waits on the master side, until the pipeline fills.
// Reset clears the position counters, the neighbor window and all valid
// flags and loads the largest grid size; the line memory is not cleared.
`default_nettype none

module wave2d_stencil_update (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [12:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // current_value [15:0], previous_value [31:16], wave_coefficient [47:32]
  input  wire logic [47:0] s_axis_tdata,
  // frame_start
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // next_value [15:0], out_row [27:16], out_col [37:28], zero [39:38]
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  localparam int unsigned SB = w2su_pkg::SampleBits;
  localparam int unsigned CB = w2su_pkg::ColBits;
  localparam int unsigned RB = w2su_pkg::RowBits;

  logic [w2su_pkg::ColCfgBits-1:0] cols_q;
  logic [w2su_pkg::RowCfgBits-1:0] rows_q;
  logic [w2su_pkg::ColCfgBits-1:0] nc;
  logic [w2su_pkg::RowCfgBits-1:0] nr;

  logic [CB-1:0] col_q, col_d;
  logic [RB-1:0] row_q, row_d;
  logic [CB-1:0] k0;
  logic [RB-1:0] r0;
  logic          emit0, last0, accept;
  logic [w2su_pkg::ColCfgBits-1:0] col_next;
  logic [w2su_pkg::RowCfgBits-1:0] row_next;

  w2su_pkg::w2su_word_t mem [w2su_pkg::MaxColumns];
  w2su_pkg::w2su_word_t rd_q, rd_eff, wr_word, fwd_word_q;

  logic          v1_q, fwd_q, s1_emit_q, s1_last_q;
  logic [CB-1:0] s1_addr_q, s1_col_q;
  logic [RB-1:0] s1_row_q;
  logic [SB-1:0] s1_g_q, s1_f_q, s1_c_q;

  logic signed [SB-1:0] win_ctr_q, win_lft_q, win_up_q, win_dn_q, win_prev_q;
  logic        [SB-1:0] win_coef_q;

  logic                                 v2_q, s2_last_q;
  logic signed [w2su_pkg::LapBits-1:0]  lap_d, s2_lap_q;
  logic signed [w2su_pkg::BaseBits-1:0] base_d, s2_base_q, s3_base_q;
  logic        [SB-1:0]                 s2_coef_q;
  logic [RB-1:0]                        s2_row_q, s3_row_q;
  logic [CB-1:0]                        s2_col_q, s3_col_q;

  logic                                 v3_q, s3_last_q;
  logic signed [SB:0]                   coef_s;
  logic signed [w2su_pkg::ProdBits-1:0] prod_d, s3_prod_q, rnd;
  logic signed [w2su_pkg::ResBits-1:0]  res;
  logic signed [SB-1:0]                 sat;

  logic          vo_q, out_last_q;
  logic [SB-1:0] out_val_q;
  logic [RB-1:0] out_row_q;
  logic [CB-1:0] out_col_q;

  logic en1, en2, en3, en_out, s1_leave;

  assign en_out        = !vo_q || m_axis_tready;
  assign en3           = !v3_q || en_out;
  assign en2           = !v2_q || en3;
  assign en1           = !v1_q || en2;
  assign s_axis_tready = en1;
  assign accept        = s_axis_tvalid && en1;
  assign s1_leave      = v1_q && en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= w2su_pkg::ColCfgBits'(w2su_pkg::MaxColumns);
      rows_q <= w2su_pkg::RowCfgBits'(w2su_pkg::MaxRows);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        w2su_pkg::RegGridColumns: cols_q <= cfg_data_i[w2su_pkg::ColCfgBits-1:0];
        w2su_pkg::RegGridRows:    rows_q <= cfg_data_i[w2su_pkg::RowCfgBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cols_q < w2su_pkg::ColCfgBits'(w2su_pkg::MinSize)) begin
      nc = w2su_pkg::ColCfgBits'(w2su_pkg::MinSize);
    end else if (cols_q > w2su_pkg::ColCfgBits'(w2su_pkg::MaxColumns)) begin
      nc = w2su_pkg::ColCfgBits'(w2su_pkg::MaxColumns);
    end else begin
      nc = cols_q;
    end
    if (rows_q < w2su_pkg::RowCfgBits'(w2su_pkg::MinSize)) begin
      nr = w2su_pkg::RowCfgBits'(w2su_pkg::MinSize);
    end else if (rows_q > w2su_pkg::RowCfgBits'(w2su_pkg::MaxRows)) begin
      nr = w2su_pkg::RowCfgBits'(w2su_pkg::MaxRows);
    end else begin
      nr = rows_q;
    end
  end

  always_comb begin
    k0    = s_axis_tuser ? '0 : col_q;
    r0    = s_axis_tuser ? '0 : row_q;
    emit0 = (r0 >= RB'(2)) && (k0 >= CB'(2)) &&
            ({1'b0, r0} < nr) && ({1'b0, k0} < nc);
    last0 = ({1'b0, r0} == nr - 1'b1) && ({1'b0, k0} == nc - 1'b1);
    col_next = {1'b0, k0} + 1'b1;
    row_next = {1'b0, r0} + 1'b1;
    if (col_next >= nc) begin
      col_d = '0;
      row_d = (row_next >= nr) ? '0 : row_next[RB-1:0];
    end else begin
      col_d = col_next[CB-1:0];
      row_d = r0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    rd_eff        = fwd_q ? fwd_word_q : rd_q;
    wr_word.g_one = s1_g_q;
    wr_word.g_two = rd_eff.g_one;
    wr_word.prev  = s1_f_q;
    wr_word.coef  = s1_c_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_leave) begin
      mem[s1_addr_q] <= wr_word;
    end
    if (accept) begin
      rd_q <= mem[k0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      fwd_q <= 1'b0;
    end else if (en1) begin
      v1_q  <= s_axis_tvalid;
      fwd_q <= v1_q && (s1_addr_q == k0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_word_q <= wr_word;
      s1_addr_q  <= k0;
      s1_g_q     <= s_axis_tdata[15:0];
      s1_f_q     <= s_axis_tdata[31:16];
      s1_c_q     <= s_axis_tdata[47:32];
      s1_emit_q  <= emit0;
      s1_last_q  <= last0;
      s1_row_q   <= r0 - 1'b1;
      s1_col_q   <= k0 - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_ctr_q  <= '0;
      win_lft_q  <= '0;
      win_up_q   <= '0;
      win_dn_q   <= '0;
      win_prev_q <= '0;
      win_coef_q <= '0;
    end else if (s1_leave) begin
      win_lft_q  <= win_ctr_q;
      win_ctr_q  <= $signed(rd_eff.g_one);
      win_up_q   <= $signed(rd_eff.g_two);
      win_dn_q   <= $signed(s1_g_q);
      win_prev_q <= $signed(rd_eff.prev);
      win_coef_q <= rd_eff.coef;
    end
  end

  always_comb begin
    lap_d = w2su_pkg::LapBits'(win_up_q) + w2su_pkg::LapBits'(win_dn_q) +
            w2su_pkg::LapBits'(win_lft_q) +
            w2su_pkg::LapBits'($signed(rd_eff.g_one)) -
            (w2su_pkg::LapBits'(win_ctr_q) <<< 2);
    base_d = (w2su_pkg::BaseBits'(win_ctr_q) <<< 1) - w2su_pkg::BaseBits'(win_prev_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_lap_q  <= lap_d;
      s2_base_q <= base_d;
      s2_coef_q <= win_coef_q;
      s2_row_q  <= s1_row_q;
      s2_col_q  <= s1_col_q;
      s2_last_q <= s1_last_q;
    end
  end

  always_comb begin
    coef_s = $signed({1'b0, s2_coef_q});
    prod_d = w2su_pkg::ProdBits'(coef_s) * w2su_pkg::ProdBits'(s2_lap_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_prod_q <= prod_d;
      s3_base_q <= s2_base_q;
      s3_row_q  <= s2_row_q;
      s3_col_q  <= s2_col_q;
      s3_last_q <= s2_last_q;
    end
  end

  always_comb begin
    rnd = s3_prod_q + $signed(w2su_pkg::RoundHalf);
    res = w2su_pkg::ResBits'($signed(rnd[w2su_pkg::ProdBits-1:w2su_pkg::FracShift])) +
          w2su_pkg::ResBits'(s3_base_q);
    if (res > w2su_pkg::ResBits'(w2su_pkg::SampleMax)) begin
      sat = w2su_pkg::SampleMax;
    end else if (res < w2su_pkg::ResBits'(w2su_pkg::SampleMin)) begin
      sat = w2su_pkg::SampleMin;
    end else begin
      sat = res[SB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_out) begin
      vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      out_val_q  <= sat;
      out_row_q  <= s3_row_q;
      out_col_q  <= s3_col_q;
      out_last_q <= s3_last_q;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {2'b00, out_col_q, out_row_q, out_val_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
